[sv/serial_packet_receiver_unit_macros.svh]
// Assertion macros shared by the receiver RTL.
// SPRX_ASSERT_NOW checks the consequent in the same cycle as the antecedent.
// SPRX_ASSERT_NEXT checks the consequent in the cycle after the antecedent.
`ifndef SERIAL_PACKET_RECEIVER_UNIT_MACROS_SVH
`define SERIAL_PACKET_RECEIVER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define SPRX_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("receiver assertion failed");
`define SPRX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("receiver assertion failed");
`else
`define SPRX_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SPRX_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[sv/sprx_pkg.sv]
package sprx_pkg;

  // Default parameter capacity of one frame.
  localparam int unsigned MAX_PARAMS_DEF = 64;

  localparam logic [7:0]  HEADER_BYTE       = 8'hFF;
  localparam logic [7:0]  DEVICE_ID_RESET   = 8'd1;
  localparam logic [15:0] GAP_LIMIT_RESET   = 16'd100;
  localparam logic [7:0]  MIN_LENGTH        = 8'd2;
  localparam logic [8:0]  FRAME_OVERHEAD    = 9'd4;

  // Frame positions with special meaning.
  localparam logic [8:0]  POS_ID            = 9'd2;
  localparam logic [8:0]  POS_LENGTH        = 9'd3;

  // Status codes of a result item.
  localparam logic [1:0]  ST_INCOMPLETE     = 2'd0;
  localparam logic [1:0]  ST_COMPLETE       = 2'd1;
  localparam logic [1:0]  ST_CHECKSUM_ERR   = 2'd2;
  localparam logic [1:0]  ST_LENGTH_ERR     = 2'd3;

  // Configuration register indexes.
  localparam logic        REG_DEVICE_ID     = 1'b0;
  localparam logic        REG_GAP_LIMIT     = 1'b1;

  typedef struct packed {
    logic [7:0]  rx_byte;
    logic [15:0] idle_ticks;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [8:0] byte_position;
    logic [7:0] data_byte;
    logic [8:0] frame_bytes;
  } out_t;

  typedef struct packed {
    logic [8:0] byte_count;
    logic [7:0] length_byte;
    logic [7:0] running_sum;
  } frame_state_t;

endpackage

[sv/sprx_parse.sv]
module sprx_parse #(
  parameter int unsigned MAX_PARAMS = sprx_pkg::MAX_PARAMS_DEF
) (
  input  sprx_pkg::in_t         item,
  input  sprx_pkg::frame_state_t cur,
  input  logic [7:0]            device_id,
  input  logic [15:0]           gap_limit,
  output sprx_pkg::frame_state_t nxt,
  output sprx_pkg::out_t        result
);
  import sprx_pkg::*;

  localparam logic [7:0] MAX_LENGTH = 8'(MAX_PARAMS + 2);

  logic         gap_restart;
  frame_state_t base;
  logic [8:0]   count_inc;
  logic [8:0]   frame_len;
  logic [7:0]   b;

  assign b           = item.rx_byte;
  assign gap_restart = item.idle_ticks > gap_limit;
  assign base        = gap_restart ? '0 : cur;
  assign count_inc   = base.byte_count + 9'd1;
  assign frame_len   = {1'b0, base.length_byte} + FRAME_OVERHEAD;

  always_comb begin
    nxt                  = base;
    result.status        = ST_INCOMPLETE;
    result.byte_position = '0;
    result.data_byte     = b;
    result.frame_bytes   = '0;

    if (base.byte_count < POS_ID) begin
      // Header bytes: anything other than the header value drops the frame.
      if (b == HEADER_BYTE) begin
        nxt.byte_count       = count_inc;
        result.byte_position = count_inc;
      end else begin
        nxt = '0;
      end
    end else if (base.byte_count == POS_ID) begin
      if (b == device_id) begin
        nxt.byte_count       = count_inc;
        nxt.running_sum      = b;
        result.byte_position = count_inc;
      end else begin
        nxt = '0;
      end
    end else if (base.byte_count == POS_LENGTH) begin
      result.byte_position = count_inc;
      if (b < MIN_LENGTH || b > MAX_LENGTH) begin
        result.status = ST_LENGTH_ERR;
        nxt           = '0;
      end else begin
        nxt.length_byte = b;
        nxt.running_sum = base.running_sum + b;
        nxt.byte_count  = count_inc;
      end
    end else begin
      result.byte_position = count_inc;
      if (count_inc >= frame_len) begin
        // Checksum byte closes the frame.
        result.frame_bytes = frame_len;
        result.status      = (b == ~base.running_sum) ? ST_COMPLETE : ST_CHECKSUM_ERR;
        nxt                = '0;
      end else begin
        nxt.byte_count  = count_inc;
        nxt.running_sum = base.running_sum + b;
      end
    end
  end

endmodule

[sv/serial_packet_receiver_unit.sv]
// An accepted item is parsed from the input register into the result register,
// where its result is presented; a stalled result holds it back. Throughput:
// one item per cycle unless stalled, set by the single parse step between them.
// Reset (synchronous, rst_n low): framing state and valid flags clear,
// device_id returns to 1 and gap_limit to 100.
`include "serial_packet_receiver_unit_macros.svh"

module serial_packet_receiver_unit #(
  parameter int unsigned MAX_PARAMS = sprx_pkg::MAX_PARAMS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  // Input channel
  input  logic           in_valid,
  output logic           in_ready,
  input  sprx_pkg::in_t  in_data,
  // Result channel
  output logic           out_valid,
  input  logic           out_ready,
  output sprx_pkg::out_t out_data,
  // Configuration port
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic [15:0]    cfg_wdata
);
  import sprx_pkg::*;

  // Two-entry pipeline. The input register holds an accepted item until the
  // result register can take its parse result; framing state is updated in
  // the same cycle the result is registered, so each item sees the state
  // left by the one before it. The input side keeps accepting while a result
  // waits, as long as the input register drains or is empty.

  logic         s1_valid_r;
  in_t          s1_data_r;
  logic         out_valid_r;
  out_t         out_data_r;
  frame_state_t state_r;
  frame_state_t state_nxt;
  out_t         result_nxt;
  logic [7:0]   device_id_r;
  logic [15:0]  gap_limit_r;
  logic         advance;
  logic         in_fire;

  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The parse step: gap check, header and id match, length check, running
  // sum and checksum compare, all from the current framing state.
  sprx_parse #(
    .MAX_PARAMS (MAX_PARAMS)
  ) u_parse (
    .item      (s1_data_r),
    .cur       (state_r),
    .device_id (device_id_r),
    .gap_limit (gap_limit_r),
    .nxt       (state_nxt),
    .result    (result_nxt)
  );

  // Configuration registers; writes are expected only while the block is idle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_id_r <= DEVICE_ID_RESET;
      gap_limit_r <= GAP_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEVICE_ID: device_id_r <= cfg_wdata[7:0];
        REG_GAP_LIMIT: gap_limit_r <= cfg_wdata;
        default:       ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r <= in_data;
    end
  end

  // Framing state and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        state_r <= state_nxt;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result register; payload needs no reset.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= result_nxt;
    end
  end

  // Once the length byte is taken, the frame never runs past its own end.
  `SPRX_ASSERT_NOW(a_count_in_frame, clk, rst_n,
    state_r.byte_count > POS_LENGTH,
    state_r.byte_count < {1'b0, state_r.length_byte} + FRAME_OVERHEAD)

  // A closed frame reports its length at the position of its checksum byte.
  `SPRX_ASSERT_NOW(a_total_matches_pos, clk, rst_n,
    out_valid_r && (out_data_r.status == ST_COMPLETE || out_data_r.status == ST_CHECKSUM_ERR),
    out_data_r.frame_bytes == out_data_r.byte_position)

  // A dropped byte never carries a final status.
  `SPRX_ASSERT_NOW(a_drop_incomplete, clk, rst_n,
    out_valid_r && out_data_r.byte_position == 9'd0,
    out_data_r.status == ST_INCOMPLETE)

  // A stalled result with a full input register blocks the input side.
  `SPRX_ASSERT_NOW(a_stall_blocks_input, clk, rst_n,
    s1_valid_r && out_valid_r && !out_ready,
    !in_ready)

  // Framing state changes only when an item moves into the result register.
  `SPRX_ASSERT_NEXT(a_state_holds, clk, rst_n,
    !advance,
    state_r == $past(state_r))

endmodule

[tb/serial_packet_receiver_unit_tb.sv]
`timescale 1ns / 100ps

module serial_packet_receiver_unit_tb;
  import sprx_pkg::*;

  // The block is built with its default parameter capacity, and the byte
  // parser below is built with the same value.
  localparam int unsigned MAX_PARAMS = MAX_PARAMS_DEF;
  localparam logic [7:0] MAX_LENGTH = 8'(MAX_PARAMS + 2);
  localparam logic [8:0] LENGTH_SLOT = POS_LENGTH + 9'd1;

  localparam int PHASE_ITEMS = 150;
  // Settling time after the last result, so the block's input and result registers are empty.
  localparam int DRAIN_CYCLES = 4;
  // Cycles without any accepted item before the run is declared hung.
  localparam int STALL_LIMIT = 5000;
  localparam int PRINT_LIMIT = 50;

  // One row of the directed table. When pinned is set, the expected result
  // is the one typed into the row; otherwise the byte parser supplies it.
  typedef struct packed {
    in_t  item;
    logic pinned;
    out_t want;
  } vector_t;

  // One phase of the random part: register values and handshake pressure.
  typedef struct {
    logic [15:0] id_word;
    logic [15:0] gap_word;
    bit          pick_random;
    int          idle_pct;
    int          stall_pct;
  } phase_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_wdata = '0;

  // Shadow of the receiver's framing state, kept by the byte parser below,
  // and of its registers, which start at their reset values.
  logic [8:0]  rx_count = '0;
  logic [7:0]  rx_length = '0;
  logic [7:0]  rx_sum = '0;
  logic [7:0]  id_match = DEVICE_ID_RESET;
  logic [15:0] gap_max = GAP_LIMIT_RESET;

  // Expected result items, oldest first.
  out_t awaited_results [$];

  // Typed-in expectation that travels with the item on the input channel.
  logic pin_result = 1'b0;
  out_t pinned_result = '0;

  // Register values the stimulus generator shapes its frames around.
  logic [7:0]  cur_id = DEVICE_ID_RESET;
  logic [15:0] cur_gap = GAP_LIMIT_RESET;
  bit          resync_needed = 1'b0;

  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;
  int error_count = 0;
  int items_sent = 0;
  int results_seen = 0;
  int good_packets = 0;
  int checksum_errors = 0;
  int length_errors = 0;
  int settings_used = 0;

  // Directed table: extremes of the fields, the gap rule on both sides of
  // the limit, a bad header, a bad id, lengths below and above the legal
  // range, and the smallest frame once with a good and once with a bad
  // checksum. All rows run at the reset values of the registers.
  vector_t directed_rows [24] = '{
    '{'{8'h00, 16'd0},     1'b1, '{ST_INCOMPLETE,   9'd0, 8'h00, 9'd0}},
    '{'{8'hFF, 16'hFFFF},  1'b1, '{ST_INCOMPLETE,   9'd1, 8'hFF, 9'd0}},
    '{'{8'hFF, 16'd100},   1'b1, '{ST_INCOMPLETE,   9'd2, 8'hFF, 9'd0}},
    '{'{8'h02, 16'd0},     1'b1, '{ST_INCOMPLETE,   9'd0, 8'h02, 9'd0}},
    '{'{8'hFF, 16'd0},     1'b0, '0},
    '{'{8'hFF, 16'd0},     1'b0, '0},
    '{'{8'h01, 16'd0},     1'b0, '0},
    '{'{8'h01, 16'd0},     1'b1, '{ST_LENGTH_ERR,   9'd4, 8'h01, 9'd0}},
    '{'{8'hFF, 16'd0},     1'b0, '0},
    '{'{8'hFF, 16'd0},     1'b0, '0},
    '{'{8'h01, 16'd0},     1'b0, '0},
    '{'{8'h43, 16'd0},     1'b1, '{ST_LENGTH_ERR,   9'd4, 8'h43, 9'd0}},
    '{'{8'hFF, 16'd0},     1'b0, '0},
    '{'{8'hFF, 16'd0},     1'b0, '0},
    '{'{8'h01, 16'd0},     1'b0, '0},
    '{'{8'h02, 16'd0},     1'b0, '0},
    '{'{8'h03, 16'd0},     1'b0, '0},
    '{'{8'hF9, 16'd0},     1'b1, '{ST_COMPLETE,     9'd6, 8'hF9, 9'd6}},
    '{'{8'hFF, 16'd0},     1'b0, '0},
    '{'{8'hFF, 16'd0},     1'b0, '0},
    '{'{8'h01, 16'd0},     1'b0, '0},
    '{'{8'h02, 16'd0},     1'b0, '0},
    '{'{8'h03, 16'd0},     1'b0, '0},
    '{'{8'h00, 16'd0},     1'b1, '{ST_CHECKSUM_ERR, 9'd6, 8'h00, 9'd6}}
  };

  // Random phases. The extremes of both registers appear, the device id
  // once equal to the header byte, and the upper bits of the id write are
  // set in two phases to show that they are dropped.
  phase_t phase_plan [5] = '{
    '{16'hA501, 16'd100,   1'b0, 0,  0},
    '{16'h0000, 16'd0,     1'b0, 83, 0},
    '{16'h00FF, 16'hFFFF,  1'b0, 0,  83},
    '{16'h0000, 16'd0,     1'b1, 36, 36},
    '{16'hFF7E, 16'd3,     1'b0, 0,  0}
  };

  serial_packet_receiver_unit #(
    .MAX_PARAMS(MAX_PARAMS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Drops the frame in progress, as a gap, a bad header or id, a bad length
  // or the last byte of a frame does.
  function automatic void restart_frame();
    rx_count = '0;
    rx_length = '0;
    rx_sum = '0;
  endfunction

  // Works out the result item of one received byte and advances the shadow
  // framing state.
  function automatic out_t parse_byte(in_t item);
    out_t res;
    res = '0;
    res.data_byte = item.rx_byte;
    // A long silence before the byte starts a new frame with this byte.
    if (item.idle_ticks > gap_max) begin
      restart_frame();
    end
    if (rx_count < POS_ID) begin
      // Header bytes: anything but the header value is dropped.
      if (item.rx_byte == HEADER_BYTE) begin
        rx_count = rx_count + 9'd1;
        res.byte_position = rx_count;
      end else begin
        restart_frame();
      end
    end else if (rx_count == POS_ID) begin
      // Device id: the checksum sum starts here.
      if (item.rx_byte == id_match) begin
        rx_count = POS_LENGTH;
        rx_sum = item.rx_byte;
        res.byte_position = POS_LENGTH;
      end else begin
        restart_frame();
      end
    end else if (rx_count == POS_LENGTH) begin
      // Length byte: it must leave room for an instruction and fit the
      // parameter capacity.
      res.byte_position = LENGTH_SLOT;
      if (item.rx_byte < MIN_LENGTH || item.rx_byte > MAX_LENGTH) begin
        res.status = ST_LENGTH_ERR;
        restart_frame();
      end else begin
        rx_length = item.rx_byte;
        rx_sum = rx_sum + item.rx_byte;
        rx_count = LENGTH_SLOT;
      end
    end else begin
      // Instruction, parameters, and finally the checksum byte.
      rx_count = rx_count + 9'd1;
      res.byte_position = rx_count;
      if (rx_count >= {1'b0, rx_length} + FRAME_OVERHEAD) begin
        res.frame_bytes = {1'b0, rx_length} + FRAME_OVERHEAD;
        res.status = (item.rx_byte == ~rx_sum) ? ST_COMPLETE : ST_CHECKSUM_ERR;
        restart_frame();
      end else begin
        rx_sum = rx_sum + item.rx_byte;
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    if (error_count < PRINT_LIMIT) begin
      $display("MISMATCH at result %0d: %s", results_seen, what);
    end
    error_count++;
  endtask

  task automatic check_result(input out_t got, input out_t want);
    if (got.status !== want.status) begin
      report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
    end
    if (got.byte_position !== want.byte_position) begin
      report_mismatch($sformatf("byte_position %0d, expected %0d",
                                got.byte_position, want.byte_position));
    end
    if (got.data_byte !== want.data_byte) begin
      report_mismatch($sformatf("data_byte %h, expected %h", got.data_byte, want.data_byte));
    end
    if (got.frame_bytes !== want.frame_bytes) begin
      report_mismatch($sformatf("frame_bytes %0d, expected %0d",
                                got.frame_bytes, want.frame_bytes));
    end
  endtask

  // Everything is sampled at the rising edge, where the inputs driven at the
  // falling edge are stable and the block's outputs still hold the values
  // from before the edge. Register writes, accepted items and accepted
  // results are all handled here so that their order is fixed.
  always @(posedge clk) begin : scoreboard
    out_t result;
    out_t want;
    bit   moved;
    if (rst_n) begin
      moved = 1'b0;
      if (cfg_we) begin
        if (cfg_index == REG_DEVICE_ID) begin
          id_match = cfg_wdata[7:0];
        end else if (cfg_index == REG_GAP_LIMIT) begin
          gap_max = cfg_wdata;
        end
      end
      if (in_valid && in_ready) begin
        result = parse_byte(in_data);
        awaited_results.push_back(pin_result ? pinned_result : result);
        case (result.status)
          ST_COMPLETE:     good_packets++;
          ST_CHECKSUM_ERR: checksum_errors++;
          ST_LENGTH_ERR:   length_errors++;
          default: ;
        endcase
        moved = 1'b1;
      end
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("result item %h arrived with none expected", out_data));
        end else begin
          want = awaited_results.pop_front();
          check_result(out_data, want);
        end
        results_seen++;
        moved = 1'b1;
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
    end
  end

  // The receiver side decides anew at every falling edge whether to take a
  // result item in the next cycle.
  always @(negedge clk) begin
    out_ready = ($urandom_range(99) >= recv_stall_pct);
  end

  // A hung block ends the run here.
  initial begin : watchdog
    wait (quiet_cycles >= STALL_LIMIT);
    $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  // Offers one item, with a random number of idle cycles first, and returns
  // at the falling edge after it was accepted. Valid stays high into that
  // edge, so a following item keeps it high without a drop.
  task automatic send_byte(input in_t item, input logic pinned, input out_t want);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = item;
    pin_result = pinned;
    pinned_result = want;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    @(negedge clk);
    items_sent++;
  endtask

  task automatic write_reg(input logic index, input logic [15:0] value);
    cfg_we = 1'b1;
    cfg_index = index;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Waits until every expected result has come back, then lets the block's
  // pipeline settle.
  task automatic wait_drained();
    while (awaited_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Idle time that keeps the frame going.
  function automatic logic [15:0] calm_idle();
    return 16'($urandom_range(cur_gap));
  endfunction

  // Idle time beyond the gap limit, where one exists.
  function automatic logic [15:0] late_idle();
    if (cur_gap == 16'hFFFF) begin
      return 16'hFFFF;
    end
    return 16'($urandom_range(32'hFFFF, cur_gap + 32'd1));
  endfunction

  // Sends one random frame: either a well formed one with random content and
  // mostly short lengths, or line noise, a frame with a bad checksum or length,
  // a frame cut short, a frame with a bad header or id, or a frame broken by
  // a silence in the middle.
  task automatic send_frame();
    logic [7:0] frame_q [$];
    logic [7:0] len;
    logic [7:0] sum;
    logic [7:0] b;
    int         shape;
    int         cut;
    int         late_at;
    in_t        item;
    shape = $urandom_range(99);
    if (shape < 8) begin
      repeat ($urandom_range(4, 1)) begin
        item.rx_byte = 8'($urandom);
        item.idle_ticks = 16'($urandom);
        send_byte(item, 1'b0, '0);
      end
      resync_needed = 1'b1;
    end else begin
      case ($urandom_range(9))
        0: len = MAX_LENGTH;
        1: len = 8'($urandom_range(MAX_LENGTH, 11));
        2: len = $urandom_range(1) ? 8'($urandom_range(MIN_LENGTH - 1))
                                   : 8'($urandom_range(255, MAX_LENGTH + 1));
        default: len = 8'($urandom_range(10, MIN_LENGTH));
      endcase
      frame_q = '{HEADER_BYTE, HEADER_BYTE, cur_id, len};
      sum = cur_id + len;
      if (len >= MIN_LENGTH && len <= MAX_LENGTH) begin
        // Instruction and parameters, then the inverted sum.
        repeat (len - 1) begin
          b = 8'($urandom);
          frame_q.push_back(b);
          sum = sum + b;
        end
        if (shape < 20) begin
          frame_q.push_back(~sum ^ 8'($urandom_range(255, 1)));
        end else begin
          frame_q.push_back(~sum);
        end
      end
      if (shape >= 90) begin
        frame_q[$urandom_range(2)] ^= 8'($urandom_range(255, 1));
      end
      cut = frame_q.size();
      if (shape >= 80 && shape < 90) begin
        cut = $urandom_range(frame_q.size() - 1, 1);
      end
      late_at = (shape >= 72 && shape < 80) ? $urandom_range(cut - 1, 1) : -1;
      for (int i = 0; i < cut; i++) begin
        item.rx_byte = frame_q[i];
        if (i == 0) begin
          // A frame after a broken one, and now and then any frame, starts
          // after a long silence so that the receiver falls back into step.
          item.idle_ticks = (resync_needed || $urandom_range(3) == 0) ? late_idle()
                                                                      : calm_idle();
        end else begin
          item.idle_ticks = (i == late_at) ? late_idle() : calm_idle();
        end
        send_byte(item, 1'b0, '0);
      end
      resync_needed = (shape >= 72);
    end
  endtask

  initial begin : stimulus
    logic [15:0] id_word;
    logic [15:0] gap_word;
    int          phase_start;
    // Synchronous reset held low, then released at a falling edge.
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    // Directed part at the reset values of the registers, without idling.
    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i].item, directed_rows[i].pinned, directed_rows[i].want);
    end

    // Random part: registers change only once the block has gone quiet.
    foreach (phase_plan[p]) begin
      in_valid = 1'b0;
      sender_idle_pct = 0;
      recv_stall_pct = 0;
      wait_drained();
      id_word = phase_plan[p].pick_random ? 16'($urandom) : phase_plan[p].id_word;
      gap_word = phase_plan[p].pick_random ? 16'($urandom) : phase_plan[p].gap_word;
      write_reg(REG_DEVICE_ID, id_word);
      write_reg(REG_GAP_LIMIT, gap_word);
      cur_id = id_word[7:0];
      cur_gap = gap_word;
      resync_needed = 1'b0;
      settings_used++;
      sender_idle_pct = phase_plan[p].idle_pct;
      recv_stall_pct = phase_plan[p].stall_pct;
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        send_frame();
      end
    end

    in_valid = 1'b0;
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    wait_drained();

    $display("Sent %0d bytes under %0d register settings plus reset values;",
             items_sent, settings_used);
    $display("frames seen: %0d good, %0d bad checksum, %0d bad length; %0d mismatches.",
             good_packets, checksum_errors, length_errors, error_count);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
